// ----- sv/dit_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dit_pkg
// shared types and constants for the dual interval timer peripheral
// ----------------------------------------------------------------------------
package dit_pkg;

	// item kinds carried on tuser
	localparam logic [1:0] ACT_READ  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	// register offsets
	localparam logic [3:0] REG_PORT_A   = 4'h0;
	localparam logic [3:0] REG_PORT_DIR = 4'h2;
	localparam logic [3:0] REG_TA_LO    = 4'h4;
	localparam logic [3:0] REG_TA_HI    = 4'h5;
	localparam logic [3:0] REG_TB_LO    = 4'h6;
	localparam logic [3:0] REG_TB_HI    = 4'h7;
	localparam logic [3:0] REG_ICR      = 4'hd;
	localparam logic [3:0] REG_CRA      = 4'he;
	localparam logic [3:0] REG_CRB      = 4'hf;

	// reset values
	localparam logic [7:0]  PORT_A_RST   = 8'h97;
	localparam logic [7:0]  PORT_DIR_RST = 8'h3f;
	localparam logic [15:0] TIMER_RST    = 16'hffff;
	localparam logic [7:0]  RDATA_IDLE   = 8'hff;

	// width of the shared adder, holds -255 .. 65536
	localparam int unsigned ACC_W = 18;
	localparam logic [ACC_W-1:0] FULL_PERIOD = 18'h10000;

	typedef logic signed [ACC_W-1:0] acc_t;

	// operand selection for the shared adder
	typedef struct packed {
		logic sel_b;     // timer b operands
		logic use_work;  // add period to work value, else count minus cycles
	} alu_ctrl_t;

endpackage

// ----- sv/dit_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dit_alu
// shared adder for both timers: count minus elapsed cycles, or work plus period
// ----------------------------------------------------------------------------
module dit_alu (
	input  dit_pkg::alu_ctrl_t ctrl,
	input  logic [15:0]        count_a,
	input  logic [15:0]        count_b,
	input  logic [15:0]        reload_a,
	input  logic [15:0]        reload_b,
	input  logic [7:0]         cycles,
	input  dit_pkg::acc_t      work,
	output dit_pkg::acc_t      sum
);
	import dit_pkg::*;

	logic [15:0]      reload;
	logic [ACC_W-1:0] period;
	logic [ACC_W-1:0] op_a;
	logic [ACC_W-1:0] op_b;

	always_comb begin
		reload = ctrl.sel_b ? reload_b : reload_a;
		// a zero latch counts a full 16-bit period
		period = (reload == 16'd0) ? FULL_PERIOD : {2'b00, reload};
		if (ctrl.use_work) begin
			op_a = work;
			op_b = period;
		end else begin
			op_a = {2'b00, (ctrl.sel_b ? count_b : count_a)};
			op_b = ~{10'd0, cycles} + 18'd1;
		end
	end

	assign sum = acc_t'(op_a + op_b);

endmodule

// ----- sv/dual_interval_timer_nmi_peripheral.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_interval_timer_nmi_peripheral
// two 16-bit reloading down-counters with interrupt flags, mask and port a
// ----------------------------------------------------------------------------
// a read or write goes through the exec and done steps, then waits in done for a free output register
// a tick adds a subtract step per running timer and a reload step per underflow before done
// the sequencer goes back to idle as the result is loaded, one item in work at a time
// the shared 18-bit adder does one subtraction per running timer, then one add per underflow
// a new item may be taken while the previous result still waits on the master side
// arst_n clears all timer, port and interrupt state to its reset values at once
// ----------------------------------------------------------------------------
module dual_interval_timer_nmi_peripheral (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // reg_addr[3:0], wdata[11:4], tick_cycles[19:12], zero pad
	input  logic [1:0]  s_tuser,   // action[1:0]
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // rdata[7:0], nmi_pending[8], bank_base[24:9], zero pad
);
	import dit_pkg::*;

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_A_SUB = 3'd2;
	localparam logic [2:0] ST_A_ADD = 3'd3;
	localparam logic [2:0] ST_B_SUB = 3'd4;
	localparam logic [2:0] ST_B_ADD = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]  state_q;

	// captured item
	logic [1:0]  action_q;
	logic [3:0]  addr_q;
	logic [7:0]  wdata_q;
	logic [7:0]  cycles_q;

	// peripheral state
	logic [7:0]  port_a_q;
	logic [7:0]  port_dir_q;
	logic [15:0] count_a_q;
	logic [15:0] reload_a_q;
	logic [15:0] count_b_q;
	logic [15:0] reload_b_q;
	logic [7:0]  ctrl_a_q;
	logic [7:0]  ctrl_b_q;
	logic [7:0]  flags_q;
	logic [6:0]  enable_q;

	// working value of the running timer
	acc_t        work_q;
	logic [7:0]  rdata_q;

	// output register
	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;

	alu_ctrl_t   alu_ctrl;
	acc_t        alu_sum;
	logic        in_xfer;
	logic        out_free;
	logic        run_b;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// timer b is held off while control bit 6 is set
	assign run_b = ctrl_b_q[0] && !ctrl_b_q[6];

	// adder operands follow the sequencer step
	always_comb begin
		alu_ctrl.sel_b    = (state_q == ST_B_SUB) || (state_q == ST_B_ADD);
		alu_ctrl.use_work = (state_q == ST_A_ADD) || (state_q == ST_B_ADD);
	end

	dit_alu u_alu (
		.ctrl     (alu_ctrl),
		.count_a  (count_a_q),
		.count_b  (count_b_q),
		.reload_a (reload_a_q),
		.reload_b (reload_b_q),
		.cycles   (cycles_q),
		.work     (work_q),
		.sum      (alu_sum)
	);

	// item capture, payload only
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			action_q <= s_tuser;
			addr_q   <= s_tdata[3:0];
			wdata_q  <= s_tdata[11:4];
			cycles_q <= s_tdata[19:12];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			port_a_q   <= PORT_A_RST;
			port_dir_q <= PORT_DIR_RST;
			count_a_q  <= TIMER_RST;
			reload_a_q <= TIMER_RST;
			count_b_q  <= TIMER_RST;
			reload_b_q <= TIMER_RST;
			ctrl_a_q   <= 8'd0;
			ctrl_b_q   <= 8'd0;
			flags_q    <= 8'd0;
			enable_q   <= 7'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			// load a finished result, or drop one taken by the downstream side
			if ((state_q == ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					// ticks go on to the timer steps, everything else finishes here
					state_q <= (action_q == ACT_TICK) ? ST_A_SUB : ST_DONE;
					case (action_q)
						ACT_READ: begin
							// reading the flags clears them
							if (addr_q == REG_ICR) begin
								flags_q <= 8'd0;
							end
						end
						ACT_WRITE: begin
							case (addr_q)
								REG_PORT_A:   port_a_q <= wdata_q;
								REG_PORT_DIR: port_dir_q <= wdata_q;
								REG_TA_LO:    reload_a_q[7:0] <= wdata_q;
								REG_TA_HI:    reload_a_q[15:8] <= wdata_q;
								REG_TB_LO:    reload_b_q[7:0] <= wdata_q;
								REG_TB_HI:    reload_b_q[15:8] <= wdata_q;
								REG_ICR: begin
									// bit 7 picks set or clear of the mask bits
									if (wdata_q[7]) begin
										enable_q <= enable_q | wdata_q[6:0];
									end else begin
										enable_q <= enable_q & ~wdata_q[6:0];
									end
								end
								REG_CRA: begin
									ctrl_a_q <= wdata_q;
									if (wdata_q[4]) begin
										count_a_q <= reload_a_q;
									end
								end
								REG_CRB: begin
									ctrl_b_q <= wdata_q;
									if (wdata_q[4]) begin
										count_b_q <= reload_b_q;
									end
								end
								default: ;
							endcase
						end
						default: ;
					endcase
				end
				ST_A_SUB: begin
					if (ctrl_a_q[0]) begin
						work_q  <= alu_sum;
						state_q <= ST_A_ADD;
					end else begin
						state_q <= ST_B_SUB;
					end
				end
				ST_A_ADD: begin
					// one reload per underflow
					if (work_q[ACC_W-1]) begin
						work_q     <= alu_sum;
						flags_q[0] <= 1'b1;
						if (enable_q[0]) begin
							flags_q[7] <= 1'b1;
						end
					end else begin
						count_a_q <= work_q[15:0];
						state_q   <= ST_B_SUB;
					end
				end
				ST_B_SUB: begin
					if (run_b) begin
						work_q  <= alu_sum;
						state_q <= ST_B_ADD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_B_ADD: begin
					if (work_q[ACC_W-1]) begin
						work_q     <= alu_sum;
						flags_q[1] <= 1'b1;
						if (enable_q[1]) begin
							flags_q[7] <= 1'b1;
						end
					end else begin
						count_b_q <= work_q[15:0];
						state_q   <= ST_DONE;
					end
				end
				ST_DONE: begin
					// wait for a free output register
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// read data, sampled before a flag clear in the same step
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			if (action_q == ACT_READ) begin
				case (addr_q)
					REG_PORT_A:   rdata_q <= {~port_a_q[5], ~port_a_q[4], port_a_q[5:0]};
					REG_PORT_DIR: rdata_q <= port_dir_q;
					REG_TA_LO:    rdata_q <= count_a_q[7:0];
					REG_TA_HI:    rdata_q <= count_a_q[15:8];
					REG_TB_LO:    rdata_q <= count_b_q[7:0];
					REG_TB_HI:    rdata_q <= count_b_q[15:8];
					REG_ICR:      rdata_q <= flags_q;
					REG_CRA:      rdata_q <= ctrl_a_q;
					REG_CRB:      rdata_q <= ctrl_b_q;
					default:      rdata_q <= RDATA_IDLE;
				endcase
			end else begin
				rdata_q <= RDATA_IDLE;
			end
		end
	end

	// result payload: bank base is the inverted port bits in the top two bits
	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			m_tdata_q <= {7'd0, ~port_a_q[1:0], 14'd0, flags_q[7], rdata_q};
		end
	end

`ifndef SYNTHESIS
	// an accepted item is executed in the next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_EXEC))
		else $error("accepted item not executed");

	// the working value never drops below -256 while reloading
	a_work_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_A_ADD) || (state_q == ST_B_ADD)) |-> (work_q >= -acc_t'(256)))
		else $error("timer work value out of range");

	// count a only moves on a write step or the end of its reload loop
	a_count_a_src: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_a_q) |-> (($past(state_q) == ST_EXEC) || ($past(state_q) == ST_A_ADD)))
		else $error("count a changed outside its update steps");

	// a result only appears from the final step
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result issued outside the final step");
`endif

endmodule
